// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define PSA_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PSA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// Paged slot allocator package
// Field widths, codes, defaults and the transaction types of the allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

	localparam int PAGE_FIELD_W = 4;
	localparam int SLOT_FIELD_W = 6;
	localparam int OFFSET_W     = 12;
	localparam int SPP_W        = 7;
	localparam int NODE_W       = 13;
	localparam int STATUS_W     = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 2;

	localparam int PAGE_COUNT_DEF = 16;
	localparam int MAX_SLOTS_DEF  = 64;

	localparam logic [SPP_W-1:0]    SPP_RESET    = SPP_W'(64);
	localparam logic [NODE_W-1:0]   NODE_RESET   = NODE_W'(64);
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(64);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_SLOTS_PER_PAGE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NODE_BYTES        = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SLOT_OFFSET = 2'd2;

	typedef struct packed {
		logic                    op;
		logic [PAGE_FIELD_W-1:0] target_page;
		logic [SLOT_FIELD_W-1:0] free_slot;
	} psa_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic [PAGE_FIELD_W-1:0] page;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [OFFSET_W-1:0]     byte_offset;
		logic                    page_released;
	} psa_rsp_t;

	typedef struct packed {
		logic [SPP_W-1:0]    slots_per_page;
		logic [NODE_W-1:0]   node_bytes;
		logic [OFFSET_W-1:0] first_slot_offset;
	} psa_cfg_t;

endpackage

// ===== hw/rtl/psa_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One transaction moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface psa_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/paged_slot_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Paged slot allocator core
// Single-size slot allocator over a pool of pages with a free-page list.
// ----------------------------------------------------------------------------
//  Channel   Direction   Transaction
//  req       in          op, target_page, free_slot
//  rsp       out         status, page, slot, byte_offset, page_released
//  cfg       in          write enable, register index, write data
//
//  One request per cycle while results are taken; a request passes the request
//  register, then the engine, which updates the page state and loads the result
//  register together.
//  Reset brings up page zero active and on the list; no clearing pass follows.
//  A stalled result holds the engine; the request register still takes one
//  transaction while the result waits.
// ----------------------------------------------------------------------------
module paged_slot_allocator_core #(
	parameter int PAGE_COUNT = psa_pkg::PAGE_COUNT_DEF,
	parameter int MAX_SLOTS  = psa_pkg::MAX_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	psa_stream_if.sink                         req,
	psa_stream_if.source                       rsp,
	input  logic                               cfg_we,
	input  logic [psa_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [psa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import psa_pkg::*;

	psa_req_t req_s1;
	logic     valid_s1;
	psa_rsp_t rsp_q;
	logic     rsp_valid_q;
	psa_cfg_t cfg_q;
	psa_rsp_t eng_rsp;
	logic     advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= eng_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slots_per_page    <= SPP_RESET;
			cfg_q.node_bytes        <= NODE_RESET;
			cfg_q.first_slot_offset <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOTS_PER_PAGE:    cfg_q.slots_per_page    <= cfg_wdata[SPP_W-1:0];
				REG_NODE_BYTES:        cfg_q.node_bytes        <= cfg_wdata[NODE_W-1:0];
				REG_FIRST_SLOT_OFFSET: cfg_q.first_slot_offset <= cfg_wdata[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	psa_engine #(
		.PAGE_COUNT (PAGE_COUNT),
		.MAX_SLOTS  (MAX_SLOTS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.cfg    (cfg_q),
		.rsp    (eng_rsp)
	);
endmodule

// ===== hw/rtl/psa_find_first.sv =====
// ----------------------------------------------------------------------------
// Find first set
// Index of the lowest set bit of a vector, with a found flag.
// ----------------------------------------------------------------------------
module psa_find_first #(
	parameter int WIDTH = 16,
	localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
	input  logic [WIDTH-1:0] vec,
	output logic             found,
	output logic [IW-1:0]    index
);
	always_comb begin
		found = |vec;
		index = '0;
		for (int k = WIDTH - 1; k >= 0; k--) begin
			if (vec[k]) begin
				index = IW'(k);
			end
		end
	end
endmodule

// ===== hw/rtl/psa_engine.sv =====
// ----------------------------------------------------------------------------
// Allocator engine
// Page bitmaps, counts and the free-page list; one request per enabled cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psa_engine #(
	parameter int PAGE_COUNT = psa_pkg::PAGE_COUNT_DEF,
	parameter int MAX_SLOTS  = psa_pkg::MAX_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  psa_pkg::psa_req_t  req,
	input  psa_pkg::psa_cfg_t  cfg,
	output psa_pkg::psa_rsp_t  rsp
);
	import psa_pkg::*;

	localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int SW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);

	logic [MAX_SLOTS-1:0]  map_q   [PAGE_COUNT];
	logic [MAX_SLOTS-1:0]  map_d   [PAGE_COUNT];
	logic [CW-1:0]         count_q [PAGE_COUNT];
	logic [CW-1:0]         count_d [PAGE_COUNT];
	logic [PW-1:0]         next_q  [PAGE_COUNT];
	logic [PW-1:0]         next_d  [PAGE_COUNT];
	logic [PW-1:0]         prev_q  [PAGE_COUNT];
	logic [PW-1:0]         prev_d  [PAGE_COUNT];
	logic [PAGE_COUNT-1:0] active_q, active_d;
	logic [PAGE_COUNT-1:0] member_q, member_d;
	logic [PW-1:0]         head_q, head_d;
	logic                  empty_q, empty_d;

	logic [CW-1:0]         spp;
	logic [MAX_SLOTS-1:0]  slot_mask;
	logic                  page_found;
	logic [PW-1:0]         page_idx;
	logic                  fresh;
	logic [PW-1:0]         alloc_pg;
	logic [MAX_SLOTS-1:0]  map_h;
	logic [CW-1:0]         count_inc;
	logic                  slot_found;
	logic [SW-1:0]         slot_idx;
	logic [OFFSET_W-1:0]   prod;
	logic [OFFSET_W-1:0]   offset;
	logic [PW-1:0]         fp_idx;
	logic [SW-1:0]         fs_idx;
	logic                  free_ok;
	logic [CW-1:0]         count_dec;
	logic                  single_active;
	logic                  do_push, do_unlink;
	logic [PW-1:0]         push_pg, unl_pg;
	logic [PW-1:0]         un_n, un_pr;
	psa_rsp_t              rsp_d;

	always_comb begin
		if (cfg.slots_per_page == '0) begin
			spp = CW'(1);
		end else if (cfg.slots_per_page > SPP_W'(MAX_SLOTS)) begin
			spp = CW'(MAX_SLOTS);
		end else begin
			spp = CW'(cfg.slots_per_page);
		end
		for (int k = 0; k < MAX_SLOTS; k++) begin
			slot_mask[k] = CW'(k) < spp;
		end
	end

	psa_find_first #(.WIDTH(PAGE_COUNT)) u_page_find (
		.vec   (~active_q),
		.found (page_found),
		.index (page_idx)
	);

	assign fresh     = (req.op == OP_ALLOC) && empty_q && page_found;
	assign alloc_pg  = fresh ? page_idx : head_q;
	assign map_h     = fresh ? '0 : map_q[head_q];
	assign count_inc = (fresh ? '0 : count_q[head_q]) + CW'(1);

	psa_find_first #(.WIDTH(MAX_SLOTS)) u_slot_find (
		.vec   (~map_h & slot_mask),
		.found (slot_found),
		.index (slot_idx)
	);

	assign prod   = OFFSET_W'(slot_idx) * cfg.node_bytes[OFFSET_W-1:0];
	assign offset = cfg.first_slot_offset + prod;

	assign fp_idx        = PW'(req.target_page);
	assign fs_idx        = SW'(req.free_slot);
	assign free_ok       = (int'(req.target_page) < PAGE_COUNT)
		&& (int'(req.free_slot) < MAX_SLOTS)
		&& active_q[fp_idx] && map_q[fp_idx][fs_idx];
	assign count_dec     = count_q[fp_idx] - CW'(1);
	assign single_active = (active_q & (active_q - PAGE_COUNT'(1))) == '0;

	always_comb begin
		map_d     = map_q;
		count_d   = count_q;
		next_d    = next_q;
		prev_d    = prev_q;
		active_d  = active_q;
		member_d  = member_q;
		head_d    = head_q;
		empty_d   = empty_q;
		rsp_d     = '0;
		do_push   = 1'b0;
		push_pg   = '0;
		do_unlink = 1'b0;
		unl_pg    = '0;

		if (req.op == OP_ALLOC) begin
			if (empty_q && !page_found) begin
				rsp_d.status = STATUS_NO_PAGE;
			end else begin
				if (fresh) begin
					active_d[page_idx] = 1'b1;
					map_d[page_idx]    = '0;
					count_d[page_idx]  = '0;
					do_push            = 1'b1;
					push_pg            = page_idx;
				end
				if (!slot_found) begin
					do_unlink    = 1'b1;
					unl_pg       = alloc_pg;
					rsp_d.status = STATUS_NO_PAGE;
				end else begin
					map_d[alloc_pg]   = map_h | (MAX_SLOTS'(1) << slot_idx);
					count_d[alloc_pg] = count_inc;
					if (count_inc >= spp) begin
						do_unlink = 1'b1;
						unl_pg    = alloc_pg;
					end
					rsp_d.status      = STATUS_OK;
					rsp_d.page        = PAGE_FIELD_W'(alloc_pg);
					rsp_d.slot        = SLOT_FIELD_W'(slot_idx);
					rsp_d.byte_offset = offset;
				end
			end
		end else begin
			rsp_d.page = req.target_page;
			rsp_d.slot = req.free_slot;
			if (!free_ok) begin
				rsp_d.status = STATUS_BAD_FREE;
			end else begin
				rsp_d.status    = STATUS_OK;
				map_d[fp_idx]   = map_q[fp_idx] & ~(MAX_SLOTS'(1) << fs_idx);
				count_d[fp_idx] = count_dec;
				if (count_dec == '0) begin
					if (single_active) begin
						if (!member_q[fp_idx]) begin
							do_push = 1'b1;
							push_pg = fp_idx;
						end
					end else begin
						if (member_q[fp_idx]) begin
							do_unlink = 1'b1;
							unl_pg    = fp_idx;
						end
						active_d[fp_idx]    = 1'b0;
						map_d[fp_idx]       = '0;
						rsp_d.page_released = 1'b1;
					end
				end else if (!member_q[fp_idx]) begin
					do_push = 1'b1;
					push_pg = fp_idx;
				end
			end
		end

		// push onto the list head
		if (do_push) begin
			if (empty_d) begin
				next_d[push_pg] = push_pg;
				empty_d         = 1'b0;
			end else begin
				next_d[push_pg] = head_d;
				prev_d[head_d]  = push_pg;
			end
			prev_d[push_pg]   = push_pg;
			head_d            = push_pg;
			member_d[push_pg] = 1'b1;
		end

		// unlink from the list, self links mark the ends
		un_n  = next_d[unl_pg];
		un_pr = prev_d[unl_pg];
		if (do_unlink) begin
			if (un_pr == unl_pg) begin
				if (un_n == unl_pg) begin
					empty_d = 1'b1;
				end else begin
					head_d       = un_n;
					prev_d[un_n] = un_n;
				end
			end else if (un_n == unl_pg) begin
				next_d[un_pr] = un_pr;
			end else begin
				next_d[un_pr] = un_n;
				prev_d[un_n]  = un_pr;
			end
			member_d[unl_pg] = 1'b0;
		end
	end

	assign rsp = rsp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PAGE_COUNT; k++) begin
				map_q[k]   <= '0;
				count_q[k] <= '0;
				next_q[k]  <= '0;
				prev_q[k]  <= '0;
			end
			active_q <= PAGE_COUNT'(1);
			member_q <= PAGE_COUNT'(1);
			head_q   <= '0;
			empty_q  <= 1'b0;
		end else if (fire) begin
			map_q    <= map_d;
			count_q  <= count_d;
			next_q   <= next_d;
			prev_q   <= prev_d;
			active_q <= active_d;
			member_q <= member_d;
			head_q   <= head_d;
			empty_q  <= empty_d;
		end
	end

	`PSA_ASSERT(a_member_active, (member_q & ~active_q) == '0, "list member is not an active page")
	`PSA_ASSERT_IMP(a_head_member, !empty_q, member_q[head_q], "list head is not a list member")
	`PSA_ASSERT(a_active_nonzero, active_q != '0, "no active page left")
	`PSA_ASSERT_NEXT(a_release_clears, fire && rsp.page_released, !active_q[$past(fp_idx)], "released page still active")
endmodule

// ===== sim/paged_slot_allocator_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Paged slot allocator core testbench
// Walks a short table of allocations, frees and register settings: slot-count
// extremes, zero node size, offset wrap, a lowered slot count, a full pool and
// bad frees. Then runs phases of random traffic, its frees mostly of live nodes,
// under new settings each phase. Every result is checked against the table's
// answer or else a cycle-free page pool model. Both channels pause at random.
// ----------------------------------------------------------------------------
module paged_slot_allocator_core_test;
	import psa_pkg::*;

	localparam int PAGES       = PAGE_COUNT_DEF;
	localparam int SLOTS       = MAX_SLOTS_DEF;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 160;

	typedef enum logic {ROW_ITEM, ROW_REGS} row_kind_t;

	typedef struct {
		row_kind_t kind;
		psa_req_t  req;
		bit        typed;
		psa_rsp_t  rsp;
		int        spp;
		int        node;
		int        off;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	psa_stream_if #(.T(psa_req_t)) req_if ();
	psa_stream_if #(.T(psa_rsp_t)) rsp_if ();

	paged_slot_allocator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// pool model
	logic [SLOTS-1:0]        busy_map [PAGES];
	logic [SPP_W-1:0]        busy_cnt [PAGES];
	logic [PAGES-1:0]        live_page;
	logic [PAGE_FIELD_W-1:0] link_fwd [PAGES];
	logic [PAGE_FIELD_W-1:0] link_back [PAGES];
	logic [PAGES-1:0]        on_list;
	logic [PAGE_FIELD_W-1:0] list_top;
	bit                      list_void;
	logic [SPP_W-1:0]        reg_spp;
	logic [NODE_W-1:0]       reg_node;
	logic [OFFSET_W-1:0]     reg_offset;

	psa_rsp_t  answers_due [$];
	plan_row_t plan [$];

	bit       idling;
	bit       hand_typed;
	psa_rsp_t hand_answer;
	int       mismatches;
	int       items_taken;
	int       directed_items;
	int       settings;
	int       released;
	int       by_status [4];
	int       quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void list_push(int p);
		if (list_void) begin
			link_fwd[p] = PAGE_FIELD_W'(p);
			list_void = 1'b0;
		end else begin
			link_fwd[p] = list_top;
			link_back[list_top] = PAGE_FIELD_W'(p);
		end
		link_back[p] = PAGE_FIELD_W'(p);
		list_top = PAGE_FIELD_W'(p);
		on_list[p] = 1'b1;
	endfunction

	function automatic void list_drop(int p);
		int n;
		int b;
		n = link_fwd[p];
		b = link_back[p];
		if (b == p) begin
			if (n == p) begin
				list_void = 1'b1;
			end else begin
				list_top = PAGE_FIELD_W'(n);
				link_back[n] = PAGE_FIELD_W'(n);
			end
		end else if (n == p) begin
			link_fwd[b] = PAGE_FIELD_W'(b);
		end else begin
			link_fwd[b] = PAGE_FIELD_W'(n);
			link_back[n] = PAGE_FIELD_W'(b);
		end
		on_list[p] = 1'b0;
	endfunction

	function automatic psa_rsp_t allocator_answer(psa_req_t r);
		psa_rsp_t a;
		int spp;
		int p;
		int i;
		bit ok;
		a = '0;
		spp = (reg_spp == 0) ? 1 : (reg_spp > SLOTS) ? SLOTS : int'(reg_spp);
		if (r.op == OP_ALLOC) begin
			ok = 1'b1;
			if (list_void) begin
				p = 0;
				while (p < PAGES && live_page[p])
					p++;
				if (p == PAGES) begin
					ok = 1'b0;
					a.status = STATUS_NO_PAGE;
				end else begin
					live_page[p] = 1'b1;
					busy_map[p] = '0;
					busy_cnt[p] = '0;
					list_push(p);
				end
			end
			if (ok) begin
				p = list_top;
				i = 0;
				while (i < spp && busy_map[p][i])
					i++;
				if (i == spp) begin
					list_drop(p);
					a.status = STATUS_NO_PAGE;
				end else begin
					busy_map[p][i] = 1'b1;
					busy_cnt[p] = busy_cnt[p] + 1'b1;
					if (busy_cnt[p] >= spp)
						list_drop(p);
					a.page = PAGE_FIELD_W'(p);
					a.slot = SLOT_FIELD_W'(i);
					a.byte_offset = OFFSET_W'(32'(reg_offset) + 32'(i) * 32'(reg_node));
				end
			end
		end else begin
			p = r.target_page;
			a.page = r.target_page;
			a.slot = r.free_slot;
			if (!live_page[p] || !busy_map[p][r.free_slot]) begin
				a.status = STATUS_BAD_FREE;
			end else begin
				busy_map[p][r.free_slot] = 1'b0;
				busy_cnt[p] = busy_cnt[p] - 1'b1;
				if (busy_cnt[p] == 0) begin
					if ($countones(live_page) <= 1) begin
						if (!on_list[p])
							list_push(p);
					end else begin
						if (on_list[p])
							list_drop(p);
						live_page[p] = 1'b0;
						busy_map[p] = '0;
						a.page_released = 1'b1;
					end
				end else if (!on_list[p]) begin
					list_push(p);
				end
			end
		end
		return a;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// result check and prediction at each accepted transaction
	always @(posedge clk) begin : track
		psa_rsp_t got;
		psa_rsp_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				if (answers_due.size() == 0) begin
					note_mismatch("result with nothing pending, status", got.status, -1);
				end else begin
					want = answers_due.pop_front();
					if (got.status != want.status)
						note_mismatch("status", got.status, want.status);
					if (got.page != want.page)
						note_mismatch("page", got.page, want.page);
					if (got.slot != want.slot)
						note_mismatch("slot", got.slot, want.slot);
					if (got.byte_offset != want.byte_offset)
						note_mismatch("byte_offset", got.byte_offset, want.byte_offset);
					if (got.page_released != want.page_released)
						note_mismatch("page_released", got.page_released, want.page_released);
				end
			end
			if (req_if.valid && req_if.ready) begin
				want = allocator_answer(req_if.data);
				if (hand_typed)
					want = hand_answer;
				answers_due.push_back(want);
				items_taken++;
				by_status[want.status]++;
				if (want.page_released)
					released++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no transaction for %0d cycles", $realtime, QUIET_LIMIT);
			$display("paged_slot_allocator_core_test NOT OK");
			$finish;
		end
	end

	initial begin : rsp_pacing
		int hold;
		rsp_if.ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				rsp_if.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 19) - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// entered and left at a falling edge
	task automatic push_item(input psa_req_t r, input bit typed, input psa_rsp_t hand);
		int gap;
		gap = (idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		hand_typed = typed;
		hand_answer = hand;
		req_if.valid <= 1'b1;
		req_if.data <= r;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
	endtask

	// drain, then write all three registers
	task automatic write_regs(input int spp, input int node, input int off);
		req_if.valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SLOTS_PER_PAGE;
		cfg_wdata <= CFG_DATA_W'(spp);
		@(negedge clk);
		cfg_index <= REG_NODE_BYTES;
		cfg_wdata <= CFG_DATA_W'(node);
		@(negedge clk);
		cfg_index <= REG_FIRST_SLOT_OFFSET;
		cfg_wdata <= CFG_DATA_W'(off);
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_spp = SPP_W'(spp);
		reg_node = NODE_W'(node);
		reg_offset = OFFSET_W'(off);
		settings++;
	endtask

	function automatic void row_item(input logic op, input int pg, input int sl, input bit typed,
			input logic [STATUS_W-1:0] st, input int rpg, input int rsl, input int off,
			input logic rel);
		plan_row_t row;
		row.kind = ROW_ITEM;
		row.req.op = op;
		row.req.target_page = PAGE_FIELD_W'(pg);
		row.req.free_slot = SLOT_FIELD_W'(sl);
		row.typed = typed;
		row.rsp.status = st;
		row.rsp.page = PAGE_FIELD_W'(rpg);
		row.rsp.slot = SLOT_FIELD_W'(rsl);
		row.rsp.byte_offset = OFFSET_W'(off);
		row.rsp.page_released = rel;
		row.spp = 0;
		row.node = 0;
		row.off = 0;
		plan.push_back(row);
	endfunction

	function automatic void row_regs(input int spp, input int node, input int off);
		plan_row_t row;
		row = '{kind: ROW_REGS, req: '0, typed: 1'b0, rsp: '0, spp: spp, node: node, off: off};
		plan.push_back(row);
	endfunction

	initial begin : stimulus
		psa_req_t r;
		int alloc_pct;
		int base;
		int s0;
		int pg;
		bit found;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		idling = 1'b1;
		hand_typed = 1'b0;
		hand_answer = '0;
		mismatches = 0;
		items_taken = 0;
		settings = 0;
		released = 0;
		by_status = '{default: 0};
		quiet_cycles = 0;

		for (int p = 0; p < PAGES; p++) begin
			busy_map[p] = '0;
			busy_cnt[p] = '0;
			link_fwd[p] = '0;
			link_back[p] = '0;
		end
		live_page = PAGES'(1);
		on_list = PAGES'(1);
		list_top = '0;
		list_void = 1'b0;
		reg_spp = SPP_RESET;
		reg_node = NODE_RESET;
		reg_offset = OFFSET_RESET;

		//       op        page slot typed status           page slot offset rel
		row_item(OP_ALLOC, 0,   0,   1,    STATUS_OK,       0,   0,   64,    0);
		row_item(OP_FREE,  15,  63,  1,    STATUS_BAD_FREE, 15,  63,  0,     0);
		row_item(OP_FREE,  0,   1,   1,    STATUS_BAD_FREE, 0,   1,   0,     0);
		row_item(OP_ALLOC, 15,  63,  1,    STATUS_OK,       0,   1,   128,   0);
		row_item(OP_FREE,  0,   0,   1,    STATUS_OK,       0,   0,   0,     0);
		row_item(OP_FREE,  0,   1,   1,    STATUS_OK,       0,   1,   0,     0);
		row_regs(0, 0, 4095);
		row_item(OP_ALLOC, 0,   0,   1,    STATUS_OK,       0,   0,   4095,  0);
		row_item(OP_ALLOC, 0,   0,   1,    STATUS_OK,       1,   0,   4095,  0);
		row_item(OP_FREE,  1,   0,   1,    STATUS_OK,       1,   0,   0,     1);
		row_regs(127, 4095, 4095);
		row_item(OP_ALLOC, 0,   0,   0,    STATUS_OK,       0,   0,   0,     0);
		row_item(OP_ALLOC, 0,   0,   0,    STATUS_OK,       0,   0,   0,     0);
		row_regs(1, 4095, 4095);
		row_item(OP_ALLOC, 0,   0,   1,    STATUS_NO_PAGE,  0,   0,   0,     0);
		repeat (PAGES - 2)
			row_item(OP_ALLOC, 0, 0, 0,  STATUS_OK,       0,   0,   0,     0);
		row_item(OP_ALLOC, 0,   0,   1,    STATUS_NO_PAGE,  0,   0,   0,     0);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_REGS)
				write_regs(plan[k].spp, plan[k].node, plan[k].off);
			else
				push_item(plan[k].req, plan[k].typed, plan[k].rsp);
		end
		directed_items = items_taken;

		for (int ph = 0; ph < PHASES; ph++) begin
			idling = (ph < PHASES - 2) && (ph % 3 != 2);
			case (ph)
				0: write_regs(64, 4096, 0);
				1: write_regs(1, 8191, 4095);
				default: begin
					case ($urandom_range(0, 7))
						0: r.free_slot = 0;
						default: r.free_slot = 1;
					endcase
					write_regs(
						(r.free_slot == 0) ? $urandom_range(0, 1) * 127 :
							($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) :
							$urandom_range(1, 8),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) * 8191 :
							$urandom_range(0, 8191),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) * 4095 :
							$urandom_range(0, 4095));
				end
			endcase
			alloc_pct = $urandom_range(35, 80);
			repeat (PHASE_ITEMS) begin
				r.op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
				r.target_page = PAGE_FIELD_W'($urandom_range(0, PAGES - 1));
				r.free_slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
				// mostly free a node that is live
				if (r.op == OP_FREE && $urandom_range(0, 9) < 8) begin
					found = 1'b0;
					base = $urandom_range(0, PAGES - 1);
					for (int k = 0; k < PAGES; k++) begin
						pg = (base + k) % PAGES;
						if (!found && live_page[pg] && busy_map[pg] != '0) begin
							s0 = $urandom_range(0, SLOTS - 1);
							for (int j = 0; j < SLOTS; j++) begin
								if (!found && busy_map[pg][(s0 + j) % SLOTS]) begin
									found = 1'b1;
									r.target_page = PAGE_FIELD_W'(pg);
									r.free_slot = SLOT_FIELD_W'((s0 + j) % SLOTS);
								end
							end
						end
					end
				end
				push_item(r, 1'b0, '0);
			end
		end

		req_if.valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d transactions (%0d from the table) over %0d register settings",
			items_taken, directed_items, settings);
		$display("status ok %0d, no page %0d, bad free %0d; pages released %0d; mismatches %0d",
			by_status[STATUS_OK], by_status[STATUS_NO_PAGE], by_status[STATUS_BAD_FREE],
			released, mismatches);
		if (mismatches == 0)
			$display("paged_slot_allocator_core_test OK");
		else
			$display("paged_slot_allocator_core_test NOT OK");
		$finish;
	end

endmodule
